@@ rtl/h2d_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// h2d_pkg
// Shared constants and types of the H2 header deframer.
// ---------------------------------------------------------------------------
package h2d_pkg;

    localparam int PACKET_BYTES  = 60;
    localparam int PAYLOAD_BYTES = 57;

    // Payload bytes emitted per packet, limited to what the packet holds
    localparam int EMIT_COUNT = (PAYLOAD_BYTES < PACKET_BYTES - 2) ?
                                PAYLOAD_BYTES : (PACKET_BYTES - 2);

    localparam int OFFS_W = $clog2(PACKET_BYTES);
    localparam int CNT_W  = $clog2(EMIT_COUNT + 1);

    localparam int BYTE_W = 8;
    localparam int NIB_W  = 4;
    localparam int SEQ_W  = 2;
    localparam int IDX_W  = 2;

    // Register indexes of the configuration port
    localparam logic [IDX_W-1:0] REG_FIRST_HDR  = 2'd0;
    localparam logic [IDX_W-1:0] REG_HDR_NIBBLE = 2'd1;
    localparam logic [IDX_W-1:0] REG_SYNC       = 2'd2;

    // Reset values of the registers
    localparam logic [BYTE_W-1:0] RST_FIRST_HDR  = 8'h01;
    localparam logic [NIB_W-1:0]  RST_HDR_NIBBLE = 4'h8;
    localparam logic [BYTE_W-1:0] RST_SYNC       = 8'hAD;

    // Sequence pair codes that the header allows
    localparam logic [1:0] PAIR_ZERO = 2'b00;
    localparam logic [1:0] PAIR_ONES = 2'b11;

    // Header offsets within a packet
    localparam logic [OFFS_W-1:0] OFFS_FIRST  = OFFS_W'(0);
    localparam logic [OFFS_W-1:0] OFFS_SECOND = OFFS_W'(1);
    localparam logic [OFFS_W-1:0] OFFS_SYNC   = OFFS_W'(2);
    localparam logic [OFFS_W-1:0] OFFS_LAST   = OFFS_W'(PACKET_BYTES - 1);

    // Request from the collector to the emitter: a packet is complete
    typedef struct packed {
        logic             start;
        logic [SEQ_W-1:0] seq;
        logic [SEQ_W-1:0] lost;
    } frame_req_t;

    function automatic logic pair_ok(input logic [1:0] pair);
        pair_ok = (pair == PAIR_ZERO) || (pair == PAIR_ONES);
    endfunction

endpackage
`default_nettype wire

@@ rtl/h2d_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// h2d_ram
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module h2d_ram #(
    parameter int DEPTH  = 60,
    parameter int WIDTH  = 8,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data held while re is low
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

@@ rtl/h2d_collect.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// h2d_collect
// Header hunt, configuration registers and packet fill into the store.
// ---------------------------------------------------------------------------
module h2d_collect
    import h2d_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [IDX_W-1:0]  cfg_index,
    input  wire logic [BYTE_W-1:0] cfg_data,
    input  wire logic              in_accept,
    input  wire logic [BYTE_W-1:0] in_byte,
    output logic                   wr_en,
    output logic      [OFFS_W-1:0] wr_addr,
    output frame_req_t             frame_req
);

    logic [BYTE_W-1:0] first_hdr_reg;
    logic [NIB_W-1:0]  hdr_nibble_reg;
    logic [BYTE_W-1:0] sync_reg;
    logic [OFFS_W-1:0] fill_reg, fill_next;
    logic [SEQ_W-1:0]  seq_reg, seq_next;
    logic [SEQ_W-1:0]  exp_reg, exp_next;
    logic              byte_ok;
    logic              complete;

    // Write configuration registers, mask to their widths
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_hdr_reg  <= RST_FIRST_HDR;
            hdr_nibble_reg <= RST_HDR_NIBBLE;
            sync_reg       <= RST_SYNC;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_FIRST_HDR:  first_hdr_reg  <= cfg_data;
                REG_HDR_NIBBLE: hdr_nibble_reg <= cfg_data[NIB_W-1:0];
                REG_SYNC:       sync_reg       <= cfg_data;
                default: ;
            endcase
        end
    end

    // Check the byte against the header pattern at its offset
    always_comb begin
        case (fill_reg)
            OFFS_FIRST:  byte_ok = (in_byte == first_hdr_reg);
            OFFS_SECOND: byte_ok = (in_byte[3:0] == hdr_nibble_reg) &&
                                   pair_ok(in_byte[5:4]) && pair_ok(in_byte[7:6]);
            OFFS_SYNC:   byte_ok = (in_byte == sync_reg);
            default:     byte_ok = 1'b1;
        endcase
    end

    assign complete = in_accept && byte_ok && (fill_reg == OFFS_LAST);

    // Advance the fill offset, capture sequence, update expected sequence
    always_comb begin
        fill_next = fill_reg;
        seq_next  = seq_reg;
        exp_next  = exp_reg;
        if (in_accept) begin
            if (!byte_ok) begin
                fill_next = OFFS_FIRST;
            end else if (complete) begin
                fill_next = OFFS_FIRST;
                exp_next  = seq_reg + SEQ_W'(1);
            end else begin
                fill_next = fill_reg + OFFS_W'(1);
            end
            if (byte_ok && (fill_reg == OFFS_SECOND)) begin
                seq_next = {in_byte[7], in_byte[4]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= OFFS_FIRST;
            exp_reg  <= '0;
        end else begin
            fill_reg <= fill_next;
            exp_reg  <= exp_next;
        end
    end

    always_ff @(posedge aclk) begin
        seq_reg <= seq_next;
    end

    // Store the byte and raise the request on the last packet byte
    assign wr_en           = in_accept && byte_ok;
    assign wr_addr         = fill_reg;
    assign frame_req.start = complete;
    assign frame_req.seq   = seq_reg;
    assign frame_req.lost  = seq_reg - exp_reg;

endmodule
`default_nettype wire

@@ rtl/h2d_emit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// h2d_emit
// Reads the payload out of the store and drives the result register.
// ---------------------------------------------------------------------------
module h2d_emit
    import h2d_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire frame_req_t        frame_req,
    output logic                   busy,
    output logic                   rd_en,
    output logic      [OFFS_W-1:0] rd_addr,
    input  wire logic [BYTE_W-1:0] rd_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic      [BYTE_W-1:0] m_payload_byte,
    output logic      [SEQ_W-1:0]  m_seq_number,
    output logic      [SEQ_W-1:0]  m_lost_count,
    output logic                   m_last_of_frame
);

    logic [CNT_W-1:0]  rem_reg;
    logic [OFFS_W-1:0] addr_reg;
    logic [SEQ_W-1:0]  pkt_seq_reg;
    logic [SEQ_W-1:0]  pkt_lost_reg;
    logic              rd_valid_reg;
    logic              rd_last_reg;
    logic [SEQ_W-1:0]  rd_seq_reg;
    logic [SEQ_W-1:0]  rd_lost_reg;
    logic              m_valid_reg;
    logic [BYTE_W-1:0] m_byte_reg;
    logic              m_last_reg;
    logic [SEQ_W-1:0]  m_seq_reg;
    logic [SEQ_W-1:0]  m_lost_reg;
    logic              adv;
    logic              issue;

    // Move the pipeline when the result register is free or taken
    assign adv   = !m_valid_reg || m_ready;
    assign issue = adv && (rem_reg != '0);
    assign busy  = (rem_reg != '0);

    // Read sequencer: count down the payload bytes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= '0;
        end else if (frame_req.start) begin
            rem_reg <= CNT_W'(EMIT_COUNT);
        end else if (issue) begin
            rem_reg <= rem_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (frame_req.start) begin
            addr_reg     <= OFFS_SYNC;
            pkt_seq_reg  <= frame_req.seq;
            pkt_lost_reg <= frame_req.lost;
        end else if (issue) begin
            addr_reg <= addr_reg + OFFS_W'(1);
        end
    end

    // Read stage: tag the data coming out of the store
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else if (adv) begin
            rd_valid_reg <= issue;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            rd_last_reg <= (rem_reg == CNT_W'(1));
            rd_seq_reg  <= pkt_seq_reg;
            rd_lost_reg <= pkt_lost_reg;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= rd_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_byte_reg <= rd_data;
            m_last_reg <= rd_last_reg;
            m_seq_reg  <= rd_seq_reg;
            m_lost_reg <= rd_lost_reg;
        end
    end

    assign rd_en           = issue;
    assign rd_addr         = addr_reg;
    assign m_valid         = m_valid_reg;
    assign m_payload_byte  = m_byte_reg;
    assign m_seq_number    = m_seq_reg;
    assign m_lost_count    = m_lost_reg;
    assign m_last_of_frame = m_last_reg;

endmodule
`default_nettype wire

@@ rtl/wideband_speech_h2_deframer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// wideband_speech_h2_deframer
// Hunts for H2-framed packets in a byte stream and emits their payload.
//
// Input channel s_: one received byte per request. Bytes are checked against
// the two header bytes and the sync byte, then written into a packet store
// (one RAM, one write and one read port). A byte that fails a header check
// is dropped and the hunt restarts.
// Result channel m_: after the last packet byte is accepted, the payload
// (sync byte onward, EMIT_COUNT bytes) is read from the store through the
// RAM read register and the result register, one per cycle while m_ready
// is high. Each result carries the sequence number, the lost-packet count
// and a last-of-frame mark.
// Throughput: one byte per cycle while collecting; s_ready is low while the
// payload is read out, which lasts longer while m_ready is low.
// Stall: the result register and the RAM read register hold; reads pause.
// Reset: clears the fill offset, expected sequence, read count, pipeline valids and
// restores the register defaults. Store contents are not cleared.
// ---------------------------------------------------------------------------
module wideband_speech_h2_deframer
    import h2d_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [IDX_W-1:0]  cfg_index,
    input  wire logic [BYTE_W-1:0] cfg_data,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [BYTE_W-1:0] s_data_byte,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic      [BYTE_W-1:0] m_payload_byte,
    output logic      [SEQ_W-1:0]  m_seq_number,
    output logic      [SEQ_W-1:0]  m_lost_count,
    output logic                   m_last_of_frame
);

    frame_req_t        frame_req;
    logic              busy;
    logic              in_accept;
    logic              wr_en;
    logic [OFFS_W-1:0] wr_addr;
    logic              rd_en;
    logic [OFFS_W-1:0] rd_addr;
    logic [BYTE_W-1:0] rd_data;

    // Hold input while the payload is read out
    assign s_ready   = !busy;
    assign in_accept = s_valid && s_ready;

    h2d_collect u_collect (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_accept (in_accept),
        .in_byte   (s_data_byte),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .frame_req (frame_req)
    );

    h2d_ram #(
        .DEPTH  (PACKET_BYTES),
        .WIDTH  (BYTE_W),
        .ADDR_W (OFFS_W)
    ) u_store (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (s_data_byte),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    h2d_emit u_emit (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .frame_req       (frame_req),
        .busy            (busy),
        .rd_en           (rd_en),
        .rd_addr         (rd_addr),
        .rd_data         (rd_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_payload_byte  (m_payload_byte),
        .m_seq_number    (m_seq_number),
        .m_lost_count    (m_lost_count),
        .m_last_of_frame (m_last_of_frame)
    );

endmodule
`default_nettype wire

@@ test/wideband_speech_h2_deframer_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wideband_speech_h2_deframer_tb
// Drives byte streams into the H2 header deframer and checks every payload
// result against a local deframing predictor. A directed table covers header
// checks and sequence extremes, then random phases run well-formed packets,
// broken headers and noise under several register settings with random idle
// on both channels and one long result-side hold.
// ---------------------------------------------------------------------------
module wideband_speech_h2_deframer_tb
    import h2d_pkg::*;
();

    localparam int RANDOM_ITEMS   = 176;
    localparam int PHASES         = 4;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES   = 16;
    localparam int TIMEOUT_NS     = 400_000;
    localparam int MAX_REPORTS    = 10;
    localparam int DIR_ROWS       = 18;

    // Index past the last register; writes to it must be ignored
    localparam logic [IDX_W-1:0] REG_NONE = 2'd3;

    typedef enum logic {ROW_BYTE, ROW_PACKET} row_kind_t;

    // ROW_BYTE sends value alone; ROW_PACKET sends a full packet with value
    // as its second header byte and the sequence and lost count it must give
    typedef struct {
        row_kind_t         kind;
        logic [BYTE_W-1:0] value;
        logic [SEQ_W-1:0]  seq;
        logic [SEQ_W-1:0]  lost;
    } dir_row_t;

    typedef struct packed {
        logic [BYTE_W-1:0] payload;
        logic [SEQ_W-1:0]  seq;
        logic [SEQ_W-1:0]  lost;
        logic              last;
    } payload_rec_t;

    logic              aclk            = 1'b0;
    logic              aresetn         = 1'b0;
    logic              cfg_wr_en       = 1'b0;
    logic [IDX_W-1:0]  cfg_index       = '0;
    logic [BYTE_W-1:0] cfg_data        = '0;
    logic              s_valid         = 1'b0;
    logic              s_ready;
    logic [BYTE_W-1:0] s_data_byte     = '0;
    logic              m_valid;
    logic              m_ready         = 1'b0;
    logic [BYTE_W-1:0] m_payload_byte;
    logic [SEQ_W-1:0]  m_seq_number;
    logic [SEQ_W-1:0]  m_lost_count;
    logic              m_last_of_frame;

    // Predictor state and register copies
    logic [BYTE_W-1:0] hdr_first_q;
    logic [NIB_W-1:0]  hdr_nibble_q;
    logic [BYTE_W-1:0] sync_q;
    int                fill_cnt;
    logic [BYTE_W-1:0] pkt_store [64];
    logic [SEQ_W-1:0]  exp_seq;

    payload_rec_t      pending_payload [$];
    dir_row_t          dir_table [DIR_ROWS];
    int                mismatches  = 0;
    bit                tx_burst    = 1'b0;
    bit                rx_burst    = 1'b0;
    bit                rx_hold_req = 1'b0;

    wideband_speech_h2_deframer u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_payload_byte  (m_payload_byte),
        .m_seq_number    (m_seq_number),
        .m_lost_count    (m_lost_count),
        .m_last_of_frame (m_last_of_frame)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("wideband_speech_h2_deframer: mismatch");
        $finish;
    end

    function automatic bit pair_valid(input logic [1:0] pair);
        return (pair == PAIR_ZERO) || (pair == PAIR_ONES);
    endfunction

    function automatic bit second_byte_valid(input logic [BYTE_W-1:0] b);
        return (b[3:0] == hdr_nibble_q) && pair_valid(b[5:4]) && pair_valid(b[7:6]);
    endfunction

    // Build a well-formed second header byte with random sequence pairs
    function automatic logic [BYTE_W-1:0] random_header();
        logic [1:0] hi;
        logic [1:0] lo;
        hi = ($urandom_range(0, 1) != 0) ? PAIR_ONES : PAIR_ZERO;
        lo = ($urandom_range(0, 1) != 0) ? PAIR_ONES : PAIR_ZERO;
        return {hi, lo, hdr_nibble_q};
    endfunction

    // Advance the deframing state by one byte; queue the payload on completion
    function automatic void deframe_byte(input logic [BYTE_W-1:0] b);
        payload_rec_t     rec;
        logic [SEQ_W-1:0] seq;
        logic [SEQ_W-1:0] lost;
        if (fill_cnt == 0 && b != hdr_first_q) begin
            return;
        end
        if (fill_cnt == 1 && !second_byte_valid(b)) begin
            fill_cnt = 0;
            return;
        end
        if (fill_cnt == 2 && b != sync_q) begin
            fill_cnt = 0;
            return;
        end
        pkt_store[fill_cnt] = b;
        fill_cnt++;
        if (fill_cnt < PACKET_BYTES) begin
            return;
        end
        fill_cnt = 0;
        seq      = {pkt_store[1][7], pkt_store[1][4]};
        lost     = seq - exp_seq;
        exp_seq  = seq + 1'b1;
        for (int k = 0; k < EMIT_COUNT; k++) begin
            rec.payload = pkt_store[k + 2];
            rec.seq     = seq;
            rec.lost    = lost;
            rec.last    = (k == EMIT_COUNT - 1);
            pending_payload.push_back(rec);
        end
    endfunction

    // Write one register; the write enable is dropped again before returning to keep write enables apart
    task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [BYTE_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_FIRST_HDR:  hdr_first_q  = data;
            REG_HDR_NIBBLE: hdr_nibble_q = data[NIB_W-1:0];
            REG_SYNC:       sync_q       = data;
            default: ;
        endcase
    endtask

    // Offer one request on the input channel, hold it until taken, predict
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        do @(posedge aclk); while (!(s_valid && s_ready));
        deframe_byte(b);
    endtask

    // Send a complete packet; optionally put both byte extremes in the payload
    task automatic send_packet(input logic [BYTE_W-1:0] hdr2, input bit extremes);
        logic [BYTE_W-1:0] b;
        send_byte(hdr_first_q);
        send_byte(hdr2);
        send_byte(sync_q);
        for (int k = 3; k < PACKET_BYTES; k++) begin
            b = BYTE_W'($urandom);
            if (extremes && k == 3) begin
                b = 8'h00;
            end
            if (extremes && k == 4) begin
                b = 8'hFF;
            end
            send_byte(b);
        end
    endtask

    // Drop valid, wait for every queued result, then let the pipeline settle
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_payload.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Result side: random stalls, one long hold on request, compare in order
    initial begin
        int           wait_cycles;
        payload_rec_t exp_rec;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if ($urandom_range(0, 31) == 0) begin
                rx_burst = !rx_burst;
            end
            wait_cycles = rx_hold_req ? RX_HOLD_CYCLES : (rx_burst ? 0 : $urandom_range(0, 4));
            rx_hold_req = 1'b0;
            if (wait_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            if (pending_payload.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("unexpected result: byte %h seq %0d lost %0d last %0d",
                             m_payload_byte, m_seq_number, m_lost_count, m_last_of_frame);
                end
            end else begin
                exp_rec = pending_payload.pop_front();
                if (m_payload_byte !== exp_rec.payload || m_seq_number !== exp_rec.seq ||
                    m_lost_count !== exp_rec.lost || m_last_of_frame !== exp_rec.last) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("result differs: expected byte %h seq %0d lost %0d last %0d,",
                                 exp_rec.payload, exp_rec.seq, exp_rec.lost, exp_rec.last);
                        $display("                got byte %h seq %0d lost %0d last %0d",
                                 m_payload_byte, m_seq_number, m_lost_count, m_last_of_frame);
                    end
                end
            end
        end
    end

    // Stimulus: directed table, then random phases under new settings
    initial begin
        int                phase_items;
        int                pick;
        logic [BYTE_W-1:0] b;

        hdr_first_q  = RST_FIRST_HDR;
        hdr_nibble_q = RST_HDR_NIBBLE;
        sync_q       = RST_SYNC;
        fill_cnt     = 0;
        exp_seq      = '0;

        // Hunting skips, each header check failing, drop without recheck
        dir_table[0]  = '{ROW_BYTE,   8'h00, 2'd0, 2'd0};
        dir_table[1]  = '{ROW_BYTE,   8'hFF, 2'd0, 2'd0};
        dir_table[2]  = '{ROW_BYTE,   8'h01, 2'd0, 2'd0};
        dir_table[3]  = '{ROW_BYTE,   8'h18, 2'd0, 2'd0};
        dir_table[4]  = '{ROW_BYTE,   8'h01, 2'd0, 2'd0};
        dir_table[5]  = '{ROW_BYTE,   8'h07, 2'd0, 2'd0};
        dir_table[6]  = '{ROW_BYTE,   8'h01, 2'd0, 2'd0};
        dir_table[7]  = '{ROW_BYTE,   8'h48, 2'd0, 2'd0};
        dir_table[8]  = '{ROW_BYTE,   8'h01, 2'd0, 2'd0};
        dir_table[9]  = '{ROW_BYTE,   8'h08, 2'd0, 2'd0};
        dir_table[10] = '{ROW_BYTE,   8'h00, 2'd0, 2'd0};
        dir_table[11] = '{ROW_BYTE,   8'h01, 2'd0, 2'd0};
        dir_table[12] = '{ROW_BYTE,   8'h01, 2'd0, 2'd0};
        dir_table[13] = '{ROW_BYTE,   8'h08, 2'd0, 2'd0};
        // Complete packets walking every sequence number and lost count
        dir_table[14] = '{ROW_PACKET, 8'hF8, 2'd3, 2'd3};
        dir_table[15] = '{ROW_PACKET, 8'hC8, 2'd2, 2'd2};
        dir_table[16] = '{ROW_PACKET, 8'h08, 2'd0, 2'd1};
        dir_table[17] = '{ROW_PACKET, 8'h38, 2'd1, 2'd0};

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            if (dir_table[r].kind == ROW_BYTE) begin
                send_byte(dir_table[r].value);
            end else begin
                send_packet(dir_table[r].value, 1'b1);
                // Use the tabled sequence and lost count for this packet
                for (int k = pending_payload.size() - EMIT_COUNT;
                     k < pending_payload.size(); k++) begin
                    pending_payload[k].seq  = dir_table[r].seq;
                    pending_payload[k].lost = dir_table[r].lost;
                end
            end
        end
        drain_results();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    cfg_write(REG_FIRST_HDR, 8'h00);
                    cfg_write(REG_HDR_NIBBLE, 8'h00);
                    cfg_write(REG_SYNC, 8'h00);
                end
                1: begin
                    cfg_write(REG_FIRST_HDR, 8'hFF);
                    cfg_write(REG_HDR_NIBBLE, 8'hFF);
                    cfg_write(REG_SYNC, 8'hFF);
                    rx_hold_req = 1'b1;
                end
                2: begin
                    cfg_write(REG_FIRST_HDR, BYTE_W'($urandom));
                    cfg_write(REG_HDR_NIBBLE, BYTE_W'($urandom));
                    cfg_write(REG_SYNC, BYTE_W'($urandom));
                end
                default: begin
                    cfg_write(REG_NONE, 8'h5A);
                    cfg_write(REG_HDR_NIBBLE, 8'hA8);
                    cfg_write(REG_FIRST_HDR, RST_FIRST_HDR);
                    cfg_write(REG_SYNC, RST_SYNC);
                end
            endcase

            phase_items = 0;
            while (phase_items < RANDOM_ITEMS / PHASES) begin
                tx_burst = ($urandom_range(0, 3) == 0);
                pick     = $urandom_range(0, 9);
                if (pick == 0) begin
                    // Noise byte
                    send_byte(BYTE_W'($urandom));
                    phase_items += 1;
                end else if (pick == 1) begin
                    // Header start followed by a bad second header byte
                    send_byte(hdr_first_q);
                    do b = BYTE_W'($urandom); while (second_byte_valid(b));
                    send_byte(b);
                    phase_items += 2;
                end else if (pick == 2) begin
                    // Good header followed by a wrong sync byte
                    send_byte(hdr_first_q);
                    send_byte(random_header());
                    do b = BYTE_W'($urandom); while (b == sync_q);
                    send_byte(b);
                    phase_items += 3;
                end else begin
                    send_packet(random_header(), 1'b0);
                    phase_items += PACKET_BYTES;
                end
            end
            drain_results();
        end

        if (mismatches == 0) begin
            $display("wideband_speech_h2_deframer: match");
        end else begin
            $display("wideband_speech_h2_deframer: mismatch");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/h2d_pkg.sv
rtl/h2d_ram.sv
rtl/h2d_collect.sv
rtl/h2d_emit.sv
rtl/wideband_speech_h2_deframer.sv
test/wideband_speech_h2_deframer_tb.sv
